// ===== hdl/abcb_pkg.sv =====
// shared constants, types and lookup functions for the led bar effect engine
package abcb_pkg;

  localparam int BIN_COUNT    = 16;
  localparam int BIN_W        = 4;
  localparam int LEVEL_W      = 8;
  localparam int PIX_W        = 6;
  localparam int CNT_W        = 7;
  localparam int SPEED_W      = 13;
  localparam int POS_W        = 11;
  localparam int WIDE_W       = 15;
  localparam int COLOR_W      = 8;
  localparam int PHASE_W      = 6;
  localparam int TAB_IDX_W    = 5;
  localparam int LEVEL_MAX    = 255;
  localparam int STRIP_LENGTH = 64;
  localparam int EDGE_PADDING = 10;
  localparam int TABLE_LEN    = 24;
  localparam int RED_OFFSET   = 16;
  localparam int GREEN_OFFSET = 8;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 40;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_COUNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_WIDTH    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MOTION_BIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_CEIL   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_FLOOR  = 3'd4;

  localparam logic ACT_UPDATE = 1'b0;
  localparam logic ACT_READ   = 1'b1;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;      // capture the input word
    logic phase;     // level to phase
    logic color;     // table lookup and bin store
    logic speed;     // speed update and clamp
    logic move;      // position update and bounce
    logic check;     // pixel range check
    logic div_init;  // start pixel / width divide
    logic div_step;  // one quotient bit
    logic read;      // bin color read
    logic out_load;  // move result into output register
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic motion_hit;
    logic pix_oor;
    logic out_free;
  } status_t;

  // wrap a phase index onto the table, inputs stay below three turns
  function automatic logic [TAB_IDX_W-1:0] wrap_phase(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] r;
    begin
      if (v >= CNT_W'(2 * TABLE_LEN)) begin
        r = v - CNT_W'(2 * TABLE_LEN);
      end else if (v >= CNT_W'(TABLE_LEN)) begin
        r = v - CNT_W'(TABLE_LEN);
      end else begin
        r = v;
      end
      wrap_phase = r[TAB_IDX_W-1:0];
    end
  endfunction

  // floor(128 * cos^2(k * pi / 24))
  function automatic logic [COLOR_W-1:0] cos_sq(input logic [TAB_IDX_W-1:0] k);
    logic [COLOR_W-1:0] v;
    begin
      case (k)
        5'd0:    v = 8'd128;
        5'd1:    v = 8'd125;
        5'd2:    v = 8'd119;
        5'd3:    v = 8'd109;
        5'd4:    v = 8'd96;
        5'd5:    v = 8'd80;
        5'd6:    v = 8'd64;
        5'd7:    v = 8'd47;
        5'd8:    v = 8'd32;
        5'd9:    v = 8'd18;
        5'd10:   v = 8'd8;
        5'd11:   v = 8'd2;
        5'd12:   v = 8'd0;
        5'd13:   v = 8'd2;
        5'd14:   v = 8'd8;
        5'd15:   v = 8'd18;
        5'd16:   v = 8'd32;
        5'd17:   v = 8'd47;
        5'd18:   v = 8'd64;
        5'd19:   v = 8'd80;
        5'd20:   v = 8'd96;
        5'd21:   v = 8'd109;
        5'd22:   v = 8'd119;
        5'd23:   v = 8'd125;
        default: v = 8'd0;
      endcase
      cos_sq = v;
    end
  endfunction

endpackage

// ===== hdl/abcb_ctrl.sv =====
// sequencing state machine for the led bar effect engine
module abcb_ctrl
  import abcb_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    in_kind_i,
  input  status_t status_i,
  output logic    in_ready_o,
  output cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PHASE,
    ST_COLOR,
    ST_SPEED,
    ST_MOVE,
    ST_CHECK,
    ST_DIV,
    ST_READ,
    ST_DONE
  } state_e;

  state_e           state_q, state_d;
  logic [2:0]       cnt_q, cnt_d;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = (in_kind_i == ACT_READ) ? ST_CHECK : ST_PHASE;
        end
      end
      ST_PHASE: begin
        cmd_o.phase = 1'b1;
        state_d     = ST_COLOR;
      end
      ST_COLOR: begin
        cmd_o.color = 1'b1;
        state_d     = status_i.motion_hit ? ST_SPEED : ST_DONE;
      end
      ST_SPEED: begin
        cmd_o.speed = 1'b1;
        state_d     = ST_MOVE;
      end
      ST_MOVE: begin
        cmd_o.move = 1'b1;
        state_d    = ST_DONE;
      end
      ST_CHECK: begin
        cmd_o.check = 1'b1;
        if (status_i.pix_oor) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.div_init = 1'b1;
          cnt_d          = '0;
          state_d        = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 3'd1;
        if (cnt_q == 3'(PIX_W - 1)) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.read = 1'b1;
        state_d    = ST_DONE;
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ===== hdl/abcb_datapath.sv =====
// registers, bin color store, motion arithmetic and divider of the led bar engine
module abcb_datapath
  import abcb_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cmd_t                  cmd_i,
  output status_t               status_o,
  input  logic [IN_DATA_W-1:0]  in_data_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  m_valid_o,
  input  logic                  m_ready_i,
  output logic [OUT_DATA_W-1:0] m_data_o,
  output logic                  m_user_o
);

  // configuration
  logic [CNT_W-1:0]          pixel_count_q;
  logic [CNT_W-1:0]          bin_width_q;
  logic [BIN_W-1:0]          motion_bin_q;
  logic signed [SPEED_W-1:0] speed_ceil_q;
  logic signed [SPEED_W-1:0] speed_floor_q;

  // item registers
  logic [BIN_W-1:0]   bin_q;
  logic [LEVEL_W-1:0] level_q;
  logic [PIX_W-1:0]   quo_q;
  logic [CNT_W-1:0]   rem_q;
  logic [PHASE_W-1:0] phase_q;
  logic [COLOR_W-1:0] red_q, green_q, blue_q;
  logic               oor_q;

  // motion state
  logic signed [SPEED_W-1:0] speed_q;
  logic signed [POS_W-1:0]   pos_q;
  logic                      up_q;

  logic [3*COLOR_W-1:0] colors_q [BIN_COUNT];

  logic                  m_valid_q;
  logic [OUT_DATA_W-1:0] m_data_q;
  logic                  m_user_q;

  // phase = round(level * 48 / 255), divide by 255 via multiply by 257 and one fixup
  logic [13:0]        ph_x;
  logic [21:0]        ph_prod;
  logic [PHASE_W-1:0] ph_est;
  logic [13:0]        ph_rem;
  logic [PHASE_W-1:0] phase_d;

  always_comb begin
    ph_x    = 14'({level_q, 5'b0}) + 14'({level_q, 4'b0}) + 14'(LEVEL_MAX / 2);
    ph_prod = {ph_x, 8'b0} + 22'(ph_x);
    ph_est  = ph_prod[21:16];
    ph_rem  = ph_x - (14'({ph_est, 8'b0}) - 14'(ph_est));
    phase_d = (ph_rem >= 14'(LEVEL_MAX)) ? ph_est + 6'd1 : ph_est;
  end

  logic [COLOR_W-1:0] red_lut, green_lut, blue_lut;

  always_comb begin
    red_lut   = cos_sq(wrap_phase(7'(phase_q) + 7'(RED_OFFSET)));
    green_lut = cos_sq(wrap_phase(7'(phase_q) + 7'(GREEN_OFFSET)));
    blue_lut  = cos_sq(wrap_phase(7'(phase_q)));
  end

  // speed update with ceiling tested first
  logic signed [WIDE_W-1:0]  spd_sum;
  logic signed [SPEED_W-1:0] speed_d;

  always_comb begin
    spd_sum = WIDE_W'(speed_q) + $signed({6'b0, level_q, 1'b0}) - WIDE_W'(LEVEL_MAX);
    if (spd_sum > WIDE_W'(speed_ceil_q)) begin
      speed_d = speed_ceil_q;
    end else if (spd_sum < WIDE_W'(speed_floor_q)) begin
      speed_d = speed_floor_q;
    end else begin
      speed_d = spd_sum[SPEED_W-1:0];
    end
  end

  // move and bounce, upper end tested first
  logic signed [WIDE_W-1:0] mv_y;
  logic signed [WIDE_W-1:0] mv_top;
  logic signed [WIDE_W-1:0] mv_bnd;
  logic signed [WIDE_W-1:0] mv_bottom;
  logic                     up_d;
  logic signed [POS_W-1:0]  pos_d;

  always_comb begin
    mv_top    = (WIDE_W'(STRIP_LENGTH + EDGE_PADDING) - $signed({8'b0, pixel_count_q})) <<< 3;
    mv_bottom = WIDE_W'(-8 * EDGE_PADDING);
    mv_y      = up_q ? WIDE_W'(pos_q) + WIDE_W'(speed_q) : WIDE_W'(pos_q) - WIDE_W'(speed_q);
    up_d      = up_q;
    mv_bnd    = mv_y;
    if (mv_y > mv_top) begin
      up_d   = ~up_q;
      mv_bnd = mv_top;
    end else if (mv_y < mv_bottom) begin
      up_d   = ~up_q;
      mv_bnd = mv_bottom;
    end
    if (mv_bnd > WIDE_W'(1023)) begin
      pos_d = 11'sd1023;
    end else if (mv_bnd < WIDE_W'(-1024)) begin
      pos_d = -11'sd1024;
    end else begin
      pos_d = mv_bnd[POS_W-1:0];
    end
  end

  // restoring divide step, zero width acts as one
  logic [CNT_W-1:0] div_w;
  logic [CNT_W:0]   div_trial;
  logic             div_bit;

  always_comb begin
    div_w     = (bin_width_q == '0) ? CNT_W'(1) : bin_width_q;
    div_trial = {rem_q, quo_q[PIX_W-1]};
    div_bit   = (div_trial >= {1'b0, div_w});
  end

  always_comb begin
    status_o.motion_hit = (bin_q == motion_bin_q);
    status_o.pix_oor    = ({1'b0, quo_q} >= pixel_count_q);
    status_o.out_free   = !m_valid_q || m_ready_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_count_q <= CNT_W'(64);
      bin_width_q   <= CNT_W'(4);
      motion_bin_q  <= '0;
      speed_ceil_q  <= 13'sd64;
      speed_floor_q <= -13'sd64;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PIXEL_COUNT: pixel_count_q <= cfg_data_i[CNT_W-1:0];
        CFG_BIN_WIDTH:   bin_width_q   <= cfg_data_i[CNT_W-1:0];
        CFG_MOTION_BIN:  motion_bin_q  <= cfg_data_i[BIN_W-1:0];
        CFG_SPEED_CEIL:  speed_ceil_q  <= $signed(cfg_data_i);
        CFG_SPEED_FLOOR: speed_floor_q <= $signed(cfg_data_i);
        default: begin
        end
      endcase
    end
  end

  // item payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      bin_q   <= in_data_i[BIN_W-1:0];
      level_q <= in_data_i[BIN_W +: LEVEL_W];
      quo_q   <= in_data_i[BIN_W+LEVEL_W +: PIX_W];
    end
    if (cmd_i.phase) begin
      phase_q <= phase_d;
    end
    if (cmd_i.color) begin
      red_q   <= red_lut;
      green_q <= green_lut;
      blue_q  <= blue_lut;
      oor_q   <= 1'b0;
    end
    if (cmd_i.check) begin
      red_q   <= '0;
      green_q <= '0;
      blue_q  <= '0;
      oor_q   <= status_o.pix_oor;
    end
    if (cmd_i.div_init) begin
      rem_q <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= div_bit ? CNT_W'(div_trial - {1'b0, div_w}) : div_trial[CNT_W-1:0];
      quo_q <= {quo_q[PIX_W-2:0], div_bit};
    end
    // bins are a power of two, so quotient mod bins is its low bits
    if (cmd_i.read) begin
      {blue_q, green_q, red_q} <= colors_q[quo_q[BIN_W-1:0]];
    end
    if (cmd_i.out_load) begin
      m_data_q <= {4'b0, up_q, pos_q, blue_q, green_q, red_q};
      m_user_q <= oor_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q   <= '0;
      pos_q     <= '0;
      up_q      <= 1'b1;
      m_valid_q <= 1'b0;
      for (int i = 0; i < BIN_COUNT; i++) begin
        colors_q[i] <= '0;
      end
    end else begin
      if (cmd_i.color) begin
        colors_q[bin_q] <= {blue_lut, green_lut, red_lut};
      end
      if (cmd_i.speed) begin
        speed_q <= speed_d;
      end
      if (cmd_i.move) begin
        pos_q <= pos_d;
        up_q  <= up_d;
      end
      if (cmd_i.out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  assign m_valid_o = m_valid_q;
  assign m_data_o  = m_data_q;
  assign m_user_o  = m_user_q;

endmodule

// ===== hdl/audio_bar_color_and_bounce.sv =====
// top level of the led bar color and bounce effect engine
// steps, accept to result valid: phase, color and done for a bin update, with speed and
//   move after color when the motion bin moves the bar; check, the bit-serial divider, read
//   and done for a pixel read; check and done for a read past the pixel count
// flow: one word at a time, taken the cycle after the result loads into a free output register
// reset (async, active low): bins, speed, position zero, moving up, registers 64, 4, 0, 64, -64
module audio_bar_color_and_bounce
  import abcb_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // bin_index[3:0], level[11:4], pixel_index[17:12]
  input  logic                  s_axis_tuser,  // action
  // result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,  // red[7:0], green[15:8], blue[23:16],
                                               // position[34:24], moving_up[35]
  output logic                  m_axis_tuser,  // out_of_range
  // register writes
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cmd_t    cmd;
  status_t status;

  // controller: one state per arithmetic step, divider loop counted here
  abcb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_kind_i  (s_axis_tuser),
    .status_i   (status),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd)
  );

  // datapath: color store, motion state, divider and output register
  // the output register frees the controller while a result waits to be taken
  abcb_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .in_data_i  (s_axis_tdata),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .m_data_o   (m_axis_tdata),
    .m_user_o   (m_axis_tuser)
  );

endmodule

// ===== hdl/abcb_checker.sv =====
// port level checks for the led bar effect engine, bound to the top level
module abcb_checker
  import abcb_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic                  m_axis_tuser
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled result word changed");

  // a read past the pixel count carries black
  a_oor_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[23:0] == 24'd0)
    else $error("out of range read with nonzero color");

  // color channels stay within the table range
  a_color_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[7:0] <= 8'd128 && m_axis_tdata[15:8] <= 8'd128
      && m_axis_tdata[23:16] <= 8'd128)
    else $error("color channel above 128");

  // one word in flight: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready right after accept");

endmodule

bind audio_bar_color_and_bounce abcb_checker u_abcb_checker (.*);
